// ===== rtl/tbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament predictor package
// Shared sizes, counter codes, queue entry type and the saturating counter
// helper for the tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

	// Table and history sizes.
	localparam int TABLE_ENTRIES = 2048;
	localparam int HISTORY_BITS  = 11;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);

	// Queue between the front end and the back end.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 32;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [HISTORY_BITS-1:0] hist_t;
	typedef logic [QPTR_W-1:0]       qptr_t;
	typedef logic [QPTR_W:0]         qcnt_t;
	typedef logic [1:0]              ctr_t;
	typedef logic [COUNT_W-1:0]      count_t;

	// Counter codes at the two ends of the range.
	localparam ctr_t CTR_STRONG_NOT   = 2'd0;
	localparam ctr_t CTR_STRONG_TAKEN = 2'd3;

	// One classified branch as it travels through the queue.
	typedef struct packed {
		idx_t bim_idx;
		idx_t gsh_idx;
		logic taken;
	} branch_op_t;

	// Queue occupancy status.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Two-bit saturating counter step toward the given direction.
	function automatic ctr_t sat_move(ctr_t ctr, logic up);
		ctr_t res;
		res = ctr;
		if (up) begin
			if (ctr != CTR_STRONG_TAKEN) res = ctr + 2'd1;
		end else begin
			if (ctr != CTR_STRONG_NOT) res = ctr - 2'd1;
		end
		return res;
	endfunction

endpackage

// ===== rtl/tbp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament predictor front end
// Accepts resolved branches, forms the bimodal and gshare table indices and
// keeps the global outcome history.
// ----------------------------------------------------------------------------
module tbp_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   branch_valid,
	output logic                   branch_stall,
	input  logic [31:0]            branch_address,
	input  logic                   outcome_taken,
	input  tbp_pkg::queue_status_t q_status,
	input  logic                   clearing,
	output logic                   push,
	output tbp_pkg::branch_op_t    push_op
);

	tbp_pkg::hist_t hist_q;
	tbp_pkg::idx_t  bim_idx;

	// Hold off new transactions while the queue is full or the tables clear.
	assign branch_stall = q_status.full | clearing;
	assign push         = branch_valid & ~branch_stall;

	// Bimodal index is the low address bits; gshare folds in the history.
	assign bim_idx         = branch_address[tbp_pkg::IDX_W-1:0];
	assign push_op.bim_idx = bim_idx;
	assign push_op.gsh_idx = bim_idx ^ tbp_pkg::idx_t'(hist_q);
	assign push_op.taken   = outcome_taken;

	// History shifts in each outcome in acceptance order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (push) begin
			hist_q <= tbp_pkg::hist_t'({hist_q, outcome_taken});
		end
	end

endmodule

// ===== rtl/tbp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament predictor decoupling queue
// Small first-in first-out buffer of classified branches between the front
// end and the back end.
// ----------------------------------------------------------------------------
module tbp_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tbp_pkg::branch_op_t    push_op,
	input  logic                   pop,
	output tbp_pkg::branch_op_t    head_op,
	output tbp_pkg::queue_status_t status
);

	tbp_pkg::branch_op_t entries_q [tbp_pkg::QUEUE_DEPTH];
	tbp_pkg::qptr_t      wr_ptr_q;
	tbp_pkg::qptr_t      rd_ptr_q;
	tbp_pkg::qcnt_t      count_q;

	assign status.full  = (count_q == tbp_pkg::qcnt_t'(tbp_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_op      = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + tbp_pkg::qptr_t'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + tbp_pkg::qptr_t'(1);
			if (push && !pop)      count_q <= count_q + tbp_pkg::qcnt_t'(1);
			else if (pop && !push) count_q <= count_q - tbp_pkg::qcnt_t'(1);
		end
	end

endmodule

// ===== rtl/tbp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament predictor back end
// Holds the bimodal, gshare and chooser tables, clears them after reset,
// performs the read-modify-write per branch and drives the result register.
// ----------------------------------------------------------------------------
module tbp_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tbp_pkg::queue_status_t q_status,
	input  tbp_pkg::branch_op_t    head_op,
	output logic                   pop,
	output logic                   clearing,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   predicted_taken,
	output logic                   chose_bimodal,
	output logic                   bimodal_right,
	output logic                   gshare_right,
	output logic                   final_right,
	output logic [31:0]            correct_total
);

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_READ   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t              state_q;
	tbp_pkg::idx_t       clr_idx_q;
	tbp_pkg::branch_op_t op_q;
	tbp_pkg::count_t     count_q;
	logic                out_valid_q;

	// Table storage and registered read data.
	tbp_pkg::ctr_t bim_mem [tbp_pkg::TABLE_ENTRIES];
	tbp_pkg::ctr_t gsh_mem [tbp_pkg::TABLE_ENTRIES];
	tbp_pkg::ctr_t cho_mem [tbp_pkg::TABLE_ENTRIES];
	tbp_pkg::ctr_t bim_rd_q;
	tbp_pkg::ctr_t gsh_rd_q;
	tbp_pkg::ctr_t cho_rd_q;

	logic            rd_en;
	logic            fire;
	logic            wr_en;
	tbp_pkg::idx_t   wr_bim_idx;
	tbp_pkg::idx_t   wr_gsh_idx;
	tbp_pkg::ctr_t   wr_bim_data;
	tbp_pkg::ctr_t   wr_gsh_data;
	tbp_pkg::ctr_t   wr_cho_data;
	logic            bpred;
	logic            gpred;
	logic            use_bi;
	logic            pred;
	logic            bright;
	logic            gright;
	logic            fright;
	tbp_pkg::count_t count_next;

	assign clearing     = (state_q == ST_CLEAR);
	assign rd_en        = (state_q == ST_READ) & ~q_status.empty;
	assign pop          = rd_en;
	assign fire         = (state_q == ST_UPDATE) & (~out_valid_q | ~result_stall);
	assign result_valid = out_valid_q;
	assign correct_total = count_q;

	// Prediction and correctness from the counters read for this transaction.
	always_comb begin
		bpred  = bim_rd_q[1];
		gpred  = gsh_rd_q[1];
		use_bi = cho_rd_q[1];
		pred   = use_bi ? bpred : gpred;
		bright = (bpred == op_q.taken);
		gright = (gpred == op_q.taken);
		fright = (pred == op_q.taken);
		count_next = count_q;
		if (fright && count_q != '1) count_next = count_q + tbp_pkg::count_t'(1);
	end

	// Write port selection: clearing pass or counter update.
	always_comb begin
		wr_en       = 1'b0;
		wr_bim_idx  = op_q.bim_idx;
		wr_gsh_idx  = op_q.gsh_idx;
		wr_bim_data = tbp_pkg::sat_move(bim_rd_q, op_q.taken);
		wr_gsh_data = tbp_pkg::sat_move(gsh_rd_q, op_q.taken);
		wr_cho_data = (bright != gright) ? tbp_pkg::sat_move(cho_rd_q, bright) : cho_rd_q;
		if (state_q == ST_CLEAR) begin
			wr_en       = 1'b1;
			wr_bim_idx  = clr_idx_q;
			wr_gsh_idx  = clr_idx_q;
			wr_bim_data = tbp_pkg::CTR_STRONG_TAKEN;
			wr_gsh_data = tbp_pkg::CTR_STRONG_TAKEN;
			wr_cho_data = tbp_pkg::CTR_STRONG_NOT;
		end else if (fire) begin
			wr_en = 1'b1;
		end
	end

	// Table memories; the chooser shares the bimodal index.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			bim_mem[wr_bim_idx] <= wr_bim_data;
			gsh_mem[wr_gsh_idx] <= wr_gsh_data;
			cho_mem[wr_bim_idx] <= wr_cho_data;
		end
		if (rd_en) begin
			bim_rd_q <= bim_mem[head_op.bim_idx];
			gsh_rd_q <= gsh_mem[head_op.gsh_idx];
			cho_rd_q <= cho_mem[head_op.bim_idx];
		end
	end

	// Transaction held for the update step.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			op_q <= head_op;
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (fire) begin
			predicted_taken <= pred;
			chose_bimodal   <= use_bi;
			bimodal_right   <= bright;
			gshare_right    <= gright;
			final_right     <= fright;
		end
	end

	// Sequencer, clear counter, running total and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + tbp_pkg::idx_t'(1);
					if (clr_idx_q == tbp_pkg::idx_t'(tbp_pkg::TABLE_ENTRIES - 1)) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (rd_en) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (fire) begin
						count_q <= count_next;
						state_q <= ST_READ;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/tournament_branch_predictor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor (bimodal and gshare with a chooser)
// A branch goes through the queue, the table read registers and the result
// register. The back end reads and updates the tables for one branch before
// it reads the next. A four-entry queue lets the input keep accepting while
// results are stalled, until it fills. Reset: after arst_n releases, a
// clearing pass initializes the tables with branch_stall held high.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        branch_valid,
	output logic        branch_stall,
	input  logic [31:0] branch_address,
	input  logic        outcome_taken,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        predicted_taken,
	output logic        chose_bimodal,
	output logic        bimodal_right,
	output logic        gshare_right,
	output logic        final_right,
	output logic [31:0] correct_total
);

	tbp_pkg::queue_status_t q_status;
	tbp_pkg::branch_op_t    push_op;
	tbp_pkg::branch_op_t    head_op;
	logic                   push;
	logic                   pop;
	logic                   clearing;

	// Front end: acceptance, index formation and history.
	tbp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.branch_valid   (branch_valid),
		.branch_stall   (branch_stall),
		.branch_address (branch_address),
		.outcome_taken  (outcome_taken),
		.q_status       (q_status),
		.clearing       (clearing),
		.push           (push),
		.push_op        (push_op)
	);

	// Decoupling queue.
	tbp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.status  (q_status)
	);

	// Back end: tables, update and result register.
	tbp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_status        (q_status),
		.head_op         (head_op),
		.pop             (pop),
		.clearing        (clearing),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.predicted_taken (predicted_taken),
		.chose_bimodal   (chose_bimodal),
		.bimodal_right   (bimodal_right),
		.gshare_right    (gshare_right),
		.final_right     (final_right),
		.correct_total   (correct_total)
	);

endmodule

// ===== rtl/tbp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament predictor port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module tbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic        predicted_taken,
	input logic        chose_bimodal,
	input logic        bimodal_right,
	input logic        gshare_right,
	input logic        final_right,
	input logic [31:0] correct_total
);

	// A stalled result stays valid and holds its total, final verdict and prediction.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(correct_total)
			&& $stable(final_right) && $stable(predicted_taken))
		else $error("stalled result changed");

	// The final verdict follows the predictor that the chooser picked.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> final_right == (chose_bimodal ? bimodal_right : gshare_right))
		else $error("final_right does not match chosen predictor");

	// A correct prediction is already counted in the total.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && final_right |-> correct_total != 32'd0)
		else $error("correct prediction with zero total");

endmodule

bind tournament_branch_predictor_unit tbp_checker u_tbp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.result_valid    (result_valid),
	.result_stall    (result_stall),
	.predicted_taken (predicted_taken),
	.chose_bimodal   (chose_bimodal),
	.bimodal_right   (bimodal_right),
	.gshare_right    (gshare_right),
	.final_right     (final_right),
	.correct_total   (correct_total)
);

// ===== test/branch_outcome_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Branch outcome checker
// Watches both channels of the tournament branch predictor. Each accepted
// branch is run through a local bimodal/gshare/chooser model, and each
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module branch_outcome_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        branch_valid,
	input  logic        branch_stall,
	input  logic [31:0] branch_address,
	input  logic        outcome_taken,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic        predicted_taken,
	input  logic        chose_bimodal,
	input  logic        bimodal_right,
	input  logic        gshare_right,
	input  logic        final_right,
	input  logic [31:0] correct_total,
	output int          mismatches,
	output int          pending
);

	// Everything one resolved branch should report.
	typedef struct packed {
		logic            predicted_taken;
		logic            chose_bimodal;
		logic            bimodal_right;
		logic            gshare_right;
		logic            final_right;
		tbp_pkg::count_t correct_total;
	} branch_verdict_t;

	// Local copy of the predictor state.
	tbp_pkg::ctr_t   bimodal_table [tbp_pkg::TABLE_ENTRIES];
	tbp_pkg::ctr_t   gshare_table  [tbp_pkg::TABLE_ENTRIES];
	tbp_pkg::ctr_t   chooser_table [tbp_pkg::TABLE_ENTRIES];
	tbp_pkg::hist_t  outcome_history;
	tbp_pkg::count_t correct_run;

	branch_verdict_t expected_verdicts [$];
	int              mismatch_total = 0;
	int              results_checked = 0;

	assign mismatches = mismatch_total;

	// One line per mismatch.
	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_total++;
	endtask

	task automatic compare_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("transaction %0d field %s got %0h expected %0h",
				results_checked, field, got, want));
		end
	endtask

	// Two-bit saturating step toward the outcome.
	function automatic tbp_pkg::ctr_t step_counter(tbp_pkg::ctr_t ctr, logic up);
		if (up) begin
			return (ctr == tbp_pkg::CTR_STRONG_TAKEN) ? ctr : ctr + 2'd1;
		end
		return (ctr == tbp_pkg::CTR_STRONG_NOT) ? ctr : ctr - 2'd1;
	endfunction

	// Predict with the current tables, then train them on the outcome.
	function automatic branch_verdict_t resolve_branch(logic [31:0] addr, logic taken);
		tbp_pkg::idx_t   bim_idx;
		tbp_pkg::idx_t   gsh_idx;
		logic [31:0]     mixed;
		tbp_pkg::ctr_t   bim_ctr;
		tbp_pkg::ctr_t   gsh_ctr;
		tbp_pkg::ctr_t   sel_ctr;
		branch_verdict_t v;
		bim_idx = addr[tbp_pkg::IDX_W-1:0];
		mixed   = addr ^ 32'(outcome_history);
		gsh_idx = mixed[tbp_pkg::IDX_W-1:0];
		bim_ctr = bimodal_table[bim_idx];
		gsh_ctr = gshare_table[gsh_idx];
		sel_ctr = chooser_table[bim_idx];

		// The upper counter bit is the taken prediction.
		v.chose_bimodal   = sel_ctr[1];
		v.predicted_taken = sel_ctr[1] ? bim_ctr[1] : gsh_ctr[1];
		v.bimodal_right   = (bim_ctr[1] == taken);
		v.gshare_right    = (gsh_ctr[1] == taken);
		v.final_right     = (v.predicted_taken == taken);

		bimodal_table[bim_idx] = step_counter(bim_ctr, taken);
		gshare_table[gsh_idx]  = step_counter(gsh_ctr, taken);
		// The chooser only moves toward the predictor that alone was right.
		if (v.bimodal_right != v.gshare_right) begin
			chooser_table[bim_idx] = step_counter(sel_ctr, v.bimodal_right);
		end
		outcome_history = {outcome_history[tbp_pkg::HISTORY_BITS-2:0], taken};

		if (v.final_right && correct_run != '1) begin
			correct_run = correct_run + 1'b1;
		end
		v.correct_total = correct_run;
		return v;
	endfunction

	// Channel monitor: results are checked before new branches are queued.
	always @(posedge clk or negedge arst_n) begin
		branch_verdict_t want;
		if (!arst_n) begin
			for (int i = 0; i < tbp_pkg::TABLE_ENTRIES; i++) begin
				bimodal_table[i] = tbp_pkg::CTR_STRONG_TAKEN;
				gshare_table[i]  = tbp_pkg::CTR_STRONG_TAKEN;
				chooser_table[i] = tbp_pkg::CTR_STRONG_NOT;
			end
			outcome_history = '0;
			correct_run     = '0;
			expected_verdicts.delete();
			pending <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch($sformatf("transaction %0d arrived with nothing expected",
						results_checked));
				end else begin
					want = expected_verdicts.pop_front();
					compare_field("predicted_taken", 32'(predicted_taken),
						32'(want.predicted_taken));
					compare_field("chose_bimodal", 32'(chose_bimodal),
						32'(want.chose_bimodal));
					compare_field("bimodal_right", 32'(bimodal_right),
						32'(want.bimodal_right));
					compare_field("gshare_right", 32'(gshare_right),
						32'(want.gshare_right));
					compare_field("final_right", 32'(final_right),
						32'(want.final_right));
					compare_field("correct_total", correct_total, want.correct_total);
				end
				results_checked++;
			end
			if (branch_valid && !branch_stall) begin
				expected_verdicts.insert(expected_verdicts.size(),
					resolve_branch(branch_address, outcome_taken));
			end
			pending <= expected_verdicts.size();
		end
	end

endmodule

// ===== test/tournament_branch_predictor_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor testbench
// Drives resolved branches into the predictor with random gaps and result
// stalls: a directed opening, then patterned hot branches mixed with noise.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_unit_test;

	localparam int RANDOM_ITEMS = 1050;
	localparam int HOT_BRANCHES = 8;
	localparam int LONG_HOLD    = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam int IDLE_LIMIT   = 8000;

	// How a hot branch resolves from one visit to the next.
	typedef enum int {
		HABIT_ALWAYS,
		HABIT_NEVER,
		HABIT_ALTERNATE,
		HABIT_LOOP,
		HABIT_BIASED
	} branch_habit_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        branch_valid = 1'b0;
	logic        branch_stall;
	logic [31:0] branch_address = '0;
	logic        outcome_taken = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        predicted_taken;
	logic        chose_bimodal;
	logic        bimodal_right;
	logic        gshare_right;
	logic        final_right;
	logic [31:0] correct_total;

	int mismatches;
	int pending;
	int results_seen = 0;
	int idle_cycles = 0;

	tournament_branch_predictor_unit dut (.*);

	branch_outcome_checker checker_i (.*);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Reset is held low from the start and then released for good.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog on cycles in which no transaction completes on either side.
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			results_seen <= results_seen + 1;
		end
		if ((branch_valid && !branch_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: short free runs and stalls, with one long hold-off.
	initial begin : result_side
		int  run;
		int  hold;
		bit  long_done;
		long_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
			result_stall <= 1'b0;
			repeat (run) @(posedge clk);
			if (!long_done && results_seen >= 300) begin
				long_done = 1'b1;
				hold = LONG_HOLD;
			end else if ($urandom_range(0, 9) < 8) begin
				hold = $urandom_range(1, 3);
			end else begin
				hold = $urandom_range(4, 25);
			end
			result_stall <= 1'b1;
			repeat (hold) @(posedge clk);
		end
	end

	// Offer one branch transaction, wait for it to be taken, then idle for the gap, if any.
	task automatic offer_branch(input logic [31:0] addr, input logic taken, input int gap);
		branch_valid   <= 1'b1;
		branch_address <= addr;
		outcome_taken  <= taken;
		@(posedge clk);
		while (branch_stall) @(posedge clk);
		if (gap > 0) begin
			branch_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Mostly back to back or a few cycles apart, now and then a long gap.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Hold the branch side low until every result has come back.
	task automatic wait_drained();
		branch_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Branch side: directed opening, random traffic, then the verdict.
	initial begin : branch_side
		logic [31:0]   opening_addr  [17];
		logic          opening_taken [17];
		logic [31:0]   addr;
		logic          taken;
		logic [10:0]   hot_index  [HOT_BRANCHES];
		branch_habit_t hot_habit  [HOT_BRANCHES];
		int            hot_period [HOT_BRANCHES];
		int            hot_visits [HOT_BRANCHES];
		int            pick;
		int            burst_left;
		bit            dense;

		// Address extremes, index aliasing through the high bits, and a run on
		// one branch that drives the predictors apart so the chooser climbs,
		// saturates and falls back.
		opening_addr = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_F800, 32'h0000_07FF,
			32'h0000_0100, 32'h0000_0100, 32'h0000_0100, 32'h0000_0200,
			32'h0000_0100, 32'h0000_0100, 32'h0000_0100, 32'h0000_0100,
			32'h0000_0100, 32'hABCD_E100, 32'h8000_0100, 32'h5555_5555,
			32'hAAAA_AAAA};
		opening_taken = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
			1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (opening_addr[i]) begin
			offer_branch(opening_addr[i], opening_taken[i], pick_gap());
		end
		wait_drained();

		// A handful of hot branches with regular habits, as loops and tests
		// in real code would have.
		for (int k = 0; k < HOT_BRANCHES; k++) begin
			hot_index[k]  = 11'($urandom_range(0, 2047));
			hot_habit[k]  = branch_habit_t'(k % 5);
			hot_period[k] = $urandom_range(2, 7);
			hot_visits[k] = 0;
		end

		burst_left = 0;
		dense = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 600) begin
				wait_drained();
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(4, 24);
				dense = ($urandom_range(0, 3) == 0);
			end
			burst_left--;

			addr = $urandom();
			if ($urandom_range(0, 9) < 8) begin
				// Hot branch: same index, random upper address bits.
				pick = $urandom_range(0, HOT_BRANCHES - 1);
				addr[10:0] = hot_index[pick];
				case (hot_habit[pick])
					HABIT_ALWAYS:    taken = 1'b1;
					HABIT_NEVER:     taken = 1'b0;
					HABIT_ALTERNATE: taken = hot_visits[pick][0];
					HABIT_LOOP:      taken = (hot_visits[pick] % hot_period[pick])
						!= hot_period[pick] - 1;
					default:         taken = ($urandom_range(0, 9) < 8);
				endcase
				hot_visits[pick]++;
			end else begin
				// Noise: any address, any outcome.
				taken = 1'($urandom_range(0, 1));
			end
			offer_branch(addr, taken, dense ? 0 : pick_gap());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tbp_pkg.sv
rtl/tbp_front.sv
rtl/tbp_queue.sv
rtl/tbp_back.sv
rtl/tournament_branch_predictor_unit.sv
rtl/tbp_checker.sv
test/branch_outcome_checker.sv
test/tournament_branch_predictor_unit_test.sv
